// ===== src/hdlc_byte_unstuffing_deframer_defines.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef HDLC_BYTE_UNSTUFFING_DEFRAMER_DEFINES_SVH
`define HDLC_BYTE_UNSTUFFING_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define HBUD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define HBUD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/hdlcd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hdlcd_pkg;

   localparam int LINE_BYTE_WIDTH    = 8;
   localparam int FRAME_LENGTH_WIDTH = 11;

   localparam logic [LINE_BYTE_WIDTH-1:0] FLAG_BYTE   = 8'h7E;
   localparam logic [LINE_BYTE_WIDTH-1:0] ESCAPE_BYTE = 8'h7D;
   localparam logic [LINE_BYTE_WIDTH-1:0] UNMASK_BITS = 8'h20;

   typedef enum logic [1:0] {
      KIND_DATA     = 2'd0,
      KIND_COMPLETE = 2'd1,
      KIND_ABORTED  = 2'd2
   } kind_type;

   // One decoded result, handed from the unstuffing core to the output register.
   typedef struct packed {
      logic                          valid;
      logic [LINE_BYTE_WIDTH-1:0]    data_byte;
      kind_type                      kind;
      logic [FRAME_LENGTH_WIDTH-1:0] frame_length;
   } result_type;

endpackage

`default_nettype wire

// ===== src/hdlcd_unstuff.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hdlcd_unstuff import hdlcd_pkg::*; #(
   parameter int MAX_FRAME_BYTES = 2048
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step,
   input  wire logic [LINE_BYTE_WIDTH-1:0] line_byte,
   output result_type                      result
);

   localparam int CountWidth = $clog2(MAX_FRAME_BYTES);
   localparam logic [CountWidth-1:0] CountLimit = CountWidth'(MAX_FRAME_BYTES - 1);

   logic                  inside_frame_ff, inside_frame_in;
   logic                  escape_ff, escape_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [LINE_BYTE_WIDTH-1:0] unmasked;

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_frame_ff <= 1'b0;
         escape_ff       <= 1'b0;
         count_ff        <= '0;
      end else if (step) begin
         inside_frame_ff <= inside_frame_in;
         escape_ff       <= escape_in;
         count_ff        <= count_in;
      end
   end

   always_comb begin
      // Undo the escape only for the two stuffed codes.
      unmasked = line_byte;
      if (escape_ff && (line_byte == (FLAG_BYTE ^ UNMASK_BITS))) begin
         unmasked = FLAG_BYTE;
      end else if (escape_ff && (line_byte == (ESCAPE_BYTE ^ UNMASK_BITS))) begin
         unmasked = ESCAPE_BYTE;
      end
   end

   always_comb begin
      inside_frame_in     = inside_frame_ff;
      escape_in           = escape_ff;
      count_in            = count_ff;
      result.valid        = 1'b0;
      result.data_byte    = '0;
      result.kind         = KIND_DATA;
      result.frame_length = '0;
      priority if (line_byte == FLAG_BYTE) begin
         if (inside_frame_ff) begin
            result.valid        = 1'b1;
            result.kind         = KIND_COMPLETE;
            result.frame_length = FRAME_LENGTH_WIDTH'(count_ff);
         end
         inside_frame_in = ~inside_frame_ff;
         escape_in       = 1'b0;
         count_in        = '0;
      end else if (!inside_frame_ff) begin
         // Hunting: drop everything but a flag.
      end else if (line_byte == ESCAPE_BYTE) begin
         escape_in = 1'b1;
      end else if (count_ff >= CountLimit) begin
         result.valid    = 1'b1;
         result.kind     = KIND_ABORTED;
         inside_frame_in = 1'b0;
         escape_in       = 1'b0;
         count_in        = '0;
      end else begin
         result.valid     = 1'b1;
         result.data_byte = unmasked;
         escape_in        = 1'b0;
         count_in         = count_ff + 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== src/hdlc_byte_unstuffing_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// HDLC byte-unstuffing deframer.
// req channel: one line byte per transaction on req_tdata[7:0].
// rsp channel: at most one result per line byte; rsp_tuser carries the kind
//   (data byte, frame complete, frame aborted), rsp_tdata the payload byte and
//   the frame length. Flags outside a frame, escape bytes and ignored bytes
//   give no result transaction.
// Path: an accepted byte waits in the input register, is decoded when it
//   advances, and its result is loaded into the result register that drives rsp_*.
// Throughput: one byte per cycle while rsp_tready stays high; the per-byte
//   state update is a single compare-and-increment on the frame counter.
// A frame that would reach MAX_FRAME_BYTES payload bytes is aborted and the
//   block hunts for the next flag.
// Reset: synchronous, clears the valid bits of both pipeline registers and the
//   framing state (hunting, no escape, count zero); no clearing pass is needed.
// Stall: while rsp_tready is low a pending result holds; one more byte can
//   wait in the input register, then req_tready drops.

module hdlc_byte_unstuffing_deframer import hdlcd_pkg::*; #(
   parameter int MAX_FRAME_BYTES = 2048
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] line_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] data_byte, [18:8] frame_length, [23:19] 0
   output logic [1:0]       rsp_tuser    // [1:0] kind
);

`include "hdlc_byte_unstuffing_deframer_defines.svh"

   // Input register.
   logic                       in_valid_ff, in_valid_in;
   logic [LINE_BYTE_WIDTH-1:0] in_byte_ff, in_byte_in;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [LINE_BYTE_WIDTH-1:0]    rsp_data_ff, rsp_data_in;
   kind_type                      rsp_kind_ff, rsp_kind_in;
   logic [FRAME_LENGTH_WIDTH-1:0] rsp_length_ff, rsp_length_in;

   logic       req_accept;
   logic       advance;
   result_type result;

   // Advance the held byte whenever the result register is free or draining.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   hdlcd_unstuff #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) u_unstuff (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .line_byte(in_byte_ff),
      .result   (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      // Drop the result once taken; load a new one when the decode yields one.
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_length_in = rsp_length_ff;
      if (advance && result.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = result.data_byte;
         rsp_kind_in   = result.kind;
         rsp_length_in = result.frame_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {5'b0, rsp_length_ff, rsp_data_ff};

   `HBUD_ASSERT_NOW(a_full_blocks_req, in_valid_ff && rsp_valid_ff && !rsp_tready, !req_tready, "input register overrun")
   `HBUD_ASSERT_NEXT(a_accept_loads, req_accept, in_valid_ff, "accepted byte not held")
   `HBUD_ASSERT_NOW(a_complete_no_data, rsp_tvalid && (rsp_tuser == KIND_COMPLETE), rsp_tdata[7:0] == 8'h00, "complete result carries data")
   `HBUD_ASSERT_NOW(a_abort_clean, rsp_tvalid && (rsp_tuser == KIND_ABORTED), rsp_tdata[18:0] == 19'h0, "abort result not zeroed")

endmodule

`default_nettype wire

// ===== tb/hdlc_byte_unstuffing_deframer_tb.sv =====
`timescale 1ns / 1ps

module hdlc_byte_unstuffing_deframer_tb;
   import hdlcd_pkg::*;

   localparam int MAX_FRAME_BYTES = 2048;
   localparam int HOLD_CYCLES     = 400;
   localparam int RANDOM_ITEMS    = 150;

   typedef struct {
      logic [7:0]  data_byte;
      kind_type    kind;
      logic [10:0] frame_length;
   } deframe_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] line_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;            // [7:0] data_byte, [18:8] frame_length, [23:19] 0
   logic [1:0]  rsp_tuser;            // [1:0] kind

   logic [7:0]         line_bytes_pending[$];
   deframe_result_type expected_results[$];
   deframe_result_type oldest_result;

   // Predicted framing state
   bit frame_open    = 1'b0;
   bit esc_armed     = 1'b0;
   int payload_count = 0;

   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int holds_requested = 0;
   int holds_served    = 0;
   int hold_left       = 0;
   int mismatches      = 0;

   hdlc_byte_unstuffing_deframer #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // Advance the predicted state by one line byte and queue any result it causes.
   function automatic void deframe_line_byte(input logic [7:0] line_byte);
      logic [7:0] payload;
      payload = line_byte;
      if (line_byte == FLAG_BYTE) begin
         if (frame_open)
            expected_results.push_back('{8'h00, KIND_COMPLETE, 11'(payload_count)});
         frame_open    = !frame_open;
         esc_armed     = 1'b0;
         payload_count = 0;
         return;
      end
      if (!frame_open)
         return;
      if (line_byte == ESCAPE_BYTE) begin
         esc_armed = 1'b1;
         return;
      end
      if (esc_armed) begin
         if (line_byte == (FLAG_BYTE ^ UNMASK_BITS))
            payload = FLAG_BYTE;
         else if (line_byte == (ESCAPE_BYTE ^ UNMASK_BITS))
            payload = ESCAPE_BYTE;
         esc_armed = 1'b0;
      end
      if (payload_count + 1 >= MAX_FRAME_BYTES) begin
         // overflow: drop the byte, report the abort, hunt for a flag
         expected_results.push_back('{8'h00, KIND_ABORTED, 11'd0});
         frame_open    = 1'b0;
         esc_armed     = 1'b0;
         payload_count = 0;
      end else begin
         payload_count++;
         expected_results.push_back('{payload, KIND_DATA, 11'd0});
      end
   endfunction

   // Sender: offer the next pending line byte unless idling this cycle.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (line_bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= line_bytes_pending.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, started on request.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_requested) begin
         hold_left    <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
   end

   // Predict on every accepted line byte, check every accepted result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            deframe_line_byte(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: kind %0d data_byte 0x%02h frame_length %0d",
                      rsp_tuser, rsp_tdata[7:0], rsp_tdata[18:8]);
               mismatches++;
            end else begin
               oldest_result = expected_results.pop_front();
               if (rsp_tuser !== oldest_result.kind) begin
                  $error("kind: expected %0d, actual %0d", oldest_result.kind, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata[7:0] !== oldest_result.data_byte) begin
                  $error("data_byte: expected 0x%02h, actual 0x%02h",
                         oldest_result.data_byte, rsp_tdata[7:0]);
                  mismatches++;
               end
               if (rsp_tdata[18:8] !== oldest_result.frame_length) begin
                  $error("frame_length: expected %0d, actual %0d",
                         oldest_result.frame_length, rsp_tdata[18:8]);
                  mismatches++;
               end
            end
         end
      end
   end

   task automatic queue_line(input logic [7:0] line_byte);
      line_bytes_pending.push_back(line_byte);
   endtask

   // Stuff one payload byte; now and then escape an ordinary byte too.
   task automatic queue_payload(input logic [7:0] payload);
      if (payload == FLAG_BYTE || payload == ESCAPE_BYTE) begin
         queue_line(ESCAPE_BYTE);
         queue_line(payload ^ UNMASK_BITS);
      end else begin
         if ($urandom_range(15) == 0)
            queue_line(ESCAPE_BYTE);
         queue_line(payload);
      end
   endtask

   task automatic queue_frame(input int payload_len, input bit close_it);
      queue_line(FLAG_BYTE);
      repeat (payload_len) queue_payload(8'($urandom));
      if (close_it)
         queue_line(FLAG_BYTE);
   endtask

   function automatic logic [7:0] noisy_byte();
      case ($urandom_range(5))
         0:       return FLAG_BYTE;
         1:       return ESCAPE_BYTE;
         2:       return FLAG_BYTE ^ UNMASK_BITS;
         3:       return ESCAPE_BYTE ^ UNMASK_BITS;
         default: return 8'($urandom);
      endcase
   endfunction

   // Wait until every line byte is taken and every predicted result has come back.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (line_bytes_pending.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_chance);
      int target;
      send_idle_pct = idle_pct;
      stall_pct     = stall_chance;
      target        = line_bytes_pending.size() + RANDOM_ITEMS;
      while (line_bytes_pending.size() < target) begin
         if ($urandom_range(9) < 7) begin
            // well-formed frame, mostly short, sometimes with a stray escape inside
            queue_line(FLAG_BYTE);
            repeat (($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10)) begin
               if ($urandom_range(11) == 0) begin
                  queue_line(ESCAPE_BYTE);
                  queue_line(noisy_byte());
               end else begin
                  queue_payload(8'($urandom));
               end
            end
            queue_line(FLAG_BYTE);
         end else begin
            repeat ($urandom_range(1, 6)) queue_line(noisy_byte());
         end
      end
      wait_until_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: extremes, each escape rule, empty frame, bytes outside a frame.
      send_idle_pct = 0;
      stall_pct     = 0;
      queue_line(FLAG_BYTE);
      queue_line(8'h00);
      queue_line(8'hFF);
      queue_line(ESCAPE_BYTE);
      queue_line(FLAG_BYTE ^ UNMASK_BITS);
      queue_line(ESCAPE_BYTE);
      queue_line(ESCAPE_BYTE ^ UNMASK_BITS);
      queue_line(ESCAPE_BYTE);
      queue_line(8'h41);                     // escaped ordinary byte passes as is
      queue_line(ESCAPE_BYTE);
      queue_line(ESCAPE_BYTE);               // escape on escape stays armed
      queue_line(FLAG_BYTE ^ UNMASK_BITS);
      queue_line(ESCAPE_BYTE);
      queue_line(FLAG_BYTE);                 // flag with escape armed closes, clears escape
      queue_line(FLAG_BYTE);
      queue_line(FLAG_BYTE ^ UNMASK_BITS);   // must not be unmasked
      queue_line(FLAG_BYTE);
      queue_line(FLAG_BYTE);
      queue_line(FLAG_BYTE);                 // empty frame
      queue_line(ESCAPE_BYTE);               // outside a frame: ignored
      queue_line(FLAG_BYTE ^ UNMASK_BITS);
      queue_line(FLAG_BYTE);
      queue_line(FLAG_BYTE ^ UNMASK_BITS);
      queue_line(FLAG_BYTE);
      wait_until_drained();

      // Longest frame, then overflow on an escaped byte and on a plain one.
      queue_frame(MAX_FRAME_BYTES - 1, 1'b1);
      queue_frame(MAX_FRAME_BYTES - 1, 1'b0);
      queue_payload(FLAG_BYTE);
      queue_line(8'h00);
      queue_line(ESCAPE_BYTE);
      queue_line(FLAG_BYTE ^ UNMASK_BITS);
      queue_frame(3, 1'b1);
      queue_frame(MAX_FRAME_BYTES, 1'b1);
      wait_until_drained();

      run_random_phase(0, 0);
      run_random_phase(87, 0);
      run_random_phase(0, 87);
      run_random_phase(38, 38);

      // Back-pressure: hold the receiver off while the sender keeps streaming.
      send_idle_pct = 0;
      stall_pct     = 0;
      queue_frame(150, 1'b1);
      holds_requested++;
      wait_until_drained();

      repeat (20) @(negedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d expected results never arrived", expected_results.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("hdlc_byte_unstuffing_deframer_tb OK");
      else
         $display("hdlc_byte_unstuffing_deframer_tb NOT OK");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("hdlc_byte_unstuffing_deframer_tb NOT OK");
      $finish;
   end

endmodule
